// ===== design/rpn_pkg.sv =====
// Package: token and result types, opcodes, status codes and control structs.
`default_nettype none
package rpn_pkg;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_SUB    = 3'd2;
  localparam logic [2:0] OP_MUL    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;
  localparam logic [2:0] OP_FINISH = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] operand_value;
  } token_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [4:0]         stack_depth;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic start;
    logic wr_result;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic iter_op;
    logic unit_busy;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== design/rpn_muldiv.sv =====
// Iterative radix-2 multiply and signed divide unit, one bit per cycle.
`default_nettype none
module rpn_muldiv #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic         is_div,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic              busy,
  output logic [W-1:0]      result
);

  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  logic [CW-1:0] cnt;
  logic          div_mode;
  logic          neg;
  logic          divz;
  logic [W-1:0]  x;
  logic [W-1:0]  y;
  logic [W-1:0]  acc;
  logic [W:0]    rem_sh;
  logic [W:0]    rem_diff;
  logic          qbit;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  assign rem_sh   = {acc, x[W-1]};
  assign rem_diff = rem_sh - {1'b0, y};
  assign qbit     = !rem_diff[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_mode <= is_div;
      acc      <= '0;
      if (is_div) begin
        x    <= mag(a);
        y    <= mag(b);
        neg  <= a[W-1] ^ b[W-1];
        divz <= (b == '0);
      end else begin
        x    <= a;
        y    <= b;
        neg  <= 1'b0;
        divz <= 1'b0;
      end
    end else if (busy) begin
      if (div_mode) begin
        if (qbit) begin
          acc <= rem_diff[W-1:0];
        end else begin
          acc <= rem_sh[W-1:0];
        end
        x <= {x[W-2:0], qbit};
      end else begin
        if (y[0]) begin
          acc <= acc + x;
        end
        x <= {x[W-2:0], 1'b0};
        y <= {1'b0, y[W-1:1]};
      end
    end
  end

  always_comb begin
    if (!div_mode) begin
      result = acc;
    end else if (divz) begin
      result = '0;
    end else if (neg) begin
      result = ~x + W'(1);
    end else begin
      result = x;
    end
  end

endmodule
`default_nettype wire

// ===== design/rpn_datapath.sv =====
// Datapath: operand stack memory, top cache, stack pointer, ALU and result register.
`default_nettype none
module rpn_datapath #(
  parameter int STACK_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rpn_pkg::dp_cmd_t ctl,
  output rpn_pkg::dp_stat_t     stat,
  input  wire rpn_pkg::token_t  token,
  output rpn_pkg::result_t      result,
  output logic                  result_valid,
  input  wire logic             result_stall
);
  import rpn_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam logic [PW-1:0] DEPTH_MAX = PW'(STACK_DEPTH);
  localparam logic [PW-1:0] ONE       = PW'(1);
  localparam logic [PW-1:0] TWO       = PW'(2);

  logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] top;
  logic [PW-1:0]         sp;
  logic [2:0]            op;
  logic [DATA_WIDTH-1:0] val;
  logic                  res_finish;
  logic [DATA_WIDTH-1:0] res_pop;
  logic [1:0]            res_status;

  logic                  have_one;
  logic                  have_two;
  logic                  has_room;
  logic [DATA_WIDTH-1:0] a_opnd;
  logic [DATA_WIDTH-1:0] b_opnd;
  logic [PW-1:0]         sp_res;
  logic [DATA_WIDTH-1:0] alu_r;
  logic [DATA_WIDTH-1:0] unit_result;
  logic                  unit_busy;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  assign have_one = (sp != '0);
  assign have_two = (sp >= TWO);
  assign has_room = (sp != DEPTH_MAX);
  assign b_opnd   = have_one ? top : '1;
  assign a_opnd   = have_two ? rd_data : '1;
  assign sp_res   = have_two ? (sp - ONE) : ONE;
  assign alu_r    = (op == OP_ADD) ? (a_opnd + b_opnd) : (a_opnd - b_opnd);

  rpn_muldiv #(
    .W(DATA_WIDTH)
  ) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.start),
    .is_div(op == OP_DIV),
    .a     (a_opnd),
    .b     (b_opnd),
    .busy  (unit_busy),
    .result(unit_result)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(sp);
    wr_data = val;
    if (ctl.exec) begin
      case (op)
        OP_PUSH: begin
          wr_en = has_room;
        end
        OP_ADD, OP_SUB: begin
          wr_en   = 1'b1;
          wr_addr = AW'(sp_res - ONE);
          wr_data = alu_r;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
    if (ctl.wr_result) begin
      wr_en   = 1'b1;
      wr_addr = AW'(sp - ONE);
      wr_data = unit_result;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.capture && have_two) begin
      rd_data <= mem[AW'(sp - TWO)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (ctl.exec) begin
        case (op)
          OP_PUSH: begin
            if (has_room) begin
              sp <= sp + ONE;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            sp <= sp_res;
          end
          OP_FINISH: begin
            if (have_one) begin
              sp <= sp - ONE;
            end
          end
          default: begin
            sp <= sp;
          end
        endcase
      end
      if (ctl.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op  <= token.opcode;
      val <= DATA_WIDTH'(token.operand_value);
    end
    if (ctl.exec) begin
      res_finish <= 1'b0;
      res_status <= ST_OK;
      case (op)
        OP_PUSH: begin
          if (has_room) begin
            top <= val;
          end else begin
            res_status <= ST_OVER;
          end
        end
        OP_ADD, OP_SUB: begin
          top <= alu_r;
          if (!have_two) begin
            res_status <= ST_UNDER;
          end
        end
        OP_MUL, OP_DIV: begin
          if (!have_two) begin
            res_status <= ST_UNDER;
          end
        end
        OP_FINISH: begin
          res_finish <= 1'b1;
          res_pop    <= b_opnd;
          top        <= rd_data;
          if (!have_one) begin
            res_status <= ST_UNDER;
          end
        end
        default: begin
          res_status <= ST_OK;
        end
      endcase
    end
    if (ctl.wr_result) begin
      top <= unit_result;
    end
    if (ctl.load_out) begin
      result.top_value   <= 32'(res_finish ? res_pop : (have_one ? top : '0));
      result.stack_depth <= 5'(sp);
      result.status      <= res_status;
    end
  end

  always_comb begin
    stat.iter_op   = op inside {OP_MUL, OP_DIV};
    stat.unit_busy = unit_busy;
    stat.out_free  = !result_valid || !result_stall;
  end

endmodule
`default_nettype wire

// ===== design/rpn_controller.sv =====
// Controller: sequences capture, execute, iterate, write-back and result transfer.
`default_nettype none
module rpn_controller (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              token_valid,
  output logic                   token_stall,
  output rpn_pkg::dp_cmd_t       ctl,
  input  wire rpn_pkg::dp_stat_t stat
);
  import rpn_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_ITER  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctl           = '0;
    token_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (token_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        ctl.start  = stat.iter_op;
        state_next = stat.iter_op ? S_ITER : S_DONE;
      end
      S_ITER: begin
        if (!stat.unit_busy) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        ctl.wr_result = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/rpn_stack_calculator_unit.sv =====
// Top level: reverse-Polish integer evaluator with operand stack.
//
// One token is taken at a time and gives one result. Push, add, subtract,
// finish and the unused opcodes pass through the capture, execute and done
// states; multiply and divide also pass through the iterate and write states,
// using the shared radix-2 unit that resolves one bit per cycle.
// The stack lives in a single-write, registered-read memory that is read at
// most once per token for the entry below the top; the top entry is cached in
// a register. The memory has no clearing pass after reset. A waiting result
// sits in an output register while the next token is taken.
`default_nettype none
module rpn_stack_calculator_unit #(
  parameter int STACK_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            token_valid,
  output logic                 token_stall,
  input  wire rpn_pkg::token_t token,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output rpn_pkg::result_t     result
);
  import rpn_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  rpn_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .ctl        (ctl),
    .stat       (stat)
  );

  rpn_datapath #(
    .STACK_DEPTH(STACK_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .token       (token),
    .result      (result),
    .result_valid(result_valid),
    .result_stall(result_stall)
  );

endmodule
`default_nettype wire

// ===== design/rpn_checker.sv =====
// Checker on the top-level ports, attached by bind.
`default_nettype none
module rpn_checker #(
  parameter int STACK_DEPTH = 16
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             token_valid,
  input wire logic             token_stall,
  input wire rpn_pkg::token_t  token,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire rpn_pkg::result_t result
);
  import rpn_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_stall |=> token_stall)
    else $error("token taken while previous one still in work");

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_OVER |-> result.stack_depth == 5'(STACK_DEPTH))
    else $error("overflow reported on a stack that is not full");

  a_under_shallow: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_UNDER |-> result.stack_depth <= 5'd1)
    else $error("underflow reported with a deep stack");

endmodule

bind rpn_stack_calculator_unit rpn_checker #(.STACK_DEPTH(STACK_DEPTH)) u_chk (.*);
`default_nettype wire
